// ===== src/pft_pkg.sv =====
// Package for the publisher fencing table: sizes, request and status codes,
// controller state type and the controller/datapath command bundles. No dependencies.
`default_nettype none
package pft_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int FENCE_DEPTH = 32;
	localparam int ID_BITS     = 16;
	localparam int EPOCH_BITS  = 32;
	localparam int TIDX_BITS   = $clog2(TABLE_DEPTH);
	localparam int FIDX_BITS   = $clog2(FENCE_DEPTH);
	localparam int TCNT_BITS   = $clog2(TABLE_DEPTH + 1);
	localparam int FCNT_BITS   = $clog2(FENCE_DEPTH + 1);

	typedef enum logic [3:0] {
		REQ_REGISTER = 4'd0, REQ_HEARTBEAT = 4'd1, REQ_MARK_DEAD = 4'd2,
		REQ_FENCE_BOOT = 4'd3, REQ_ADVANCE = 4'd4, REQ_RESTORE_EPOCH = 4'd5,
		REQ_RESTORE_PUB = 4'd6, REQ_RESTORE_FENCE = 4'd7, REQ_FENCE_ALL = 4'd8,
		REQ_QUERY = 4'd9
	} req_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_MISS_PUB = 4'd1, ST_MISS_BOOT = 4'd2, ST_MISS_SCOPE = 4'd3,
		ST_EPOCH_INVALID = 4'd4, ST_EPOCH_STALE = 4'd5, ST_BOOT_FENCED = 4'd6,
		ST_STALE_BOOT = 4'd7, ST_LIMIT = 4'd8, ST_FENCED_PUB = 4'd9,
		ST_UNKNOWN = 4'd10, ST_EPOCH_EXHAUSTED = 4'd11, ST_EPOCH_REJECTED = 4'd12,
		ST_FENCE_FULL = 4'd13
	} status_t;

	// one-hot controller states
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_FIND   = 6'b000010,  // scan table for publisher id
		S_LIST   = 6'b000100,  // scan fence list for a boot
		S_DECIDE = 6'b001000,
		S_WALK   = 6'b010000,  // walk table entries (fence boot / fence all)
		S_DONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;        // capture request
		logic find_start;
		logic list_start;  // start fence list scan for list_key
		logic list_key_ent; // 1: key is boot of found/walk entry, 0: request boot
		logic decide;      // evaluate request and commit updates
		logic walk_start;
		logic walk_step;   // apply one walked entry
		logic emit;        // present result
	} cmd_t;

	typedef struct packed {
		logic find_done;
		logic list_done;
		logic walk_last;
		logic need_walk;   // request needs a table walk
		logic walk_list;   // walked entry needs a fence list scan
		req_t req;
	} sts_t;
endpackage
`default_nettype wire

// ===== src/pft_datapath.sv =====
// Datapath of the publisher fencing table: entry table, fence list, epoch,
// scan counters and result register. Uses pft_pkg; driven by pft_ctrl.
`default_nettype none
module pft_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pft_pkg::cmd_t                 cmd,
	output pft_pkg::sts_t                      sts,
	input  wire logic                          cfg_we,
	input  wire logic [4:0]                    cfg_wdata,
	input  wire logic [3:0]                    req_type,
	input  wire logic [pft_pkg::ID_BITS-1:0]   publisher_id,
	input  wire logic [pft_pkg::ID_BITS-1:0]   boot_id,
	input  wire logic [pft_pkg::ID_BITS-1:0]   scope_id,
	input  wire logic [pft_pkg::EPOCH_BITS-1:0] epoch_value,
	input  wire logic                          alive_in,
	input  wire logic                          fenced_in,
	output logic [3:0]                         status,
	output logic [31:0]                        detail,
	output logic                               publisher_alive,
	output logic                               boot_is_fenced,
	output logic [31:0]                        epoch_now,
	output logic [4:0]                         entry_count
);
	localparam int IB = pft_pkg::ID_BITS;
	localparam int EB = pft_pkg::EPOCH_BITS;
	localparam int TB = pft_pkg::TIDX_BITS;
	localparam int FB = pft_pkg::FIDX_BITS;
	localparam int TC = pft_pkg::TCNT_BITS;
	localparam int FC = pft_pkg::FCNT_BITS;
	localparam int TD = pft_pkg::TABLE_DEPTH;
	localparam int FD = pft_pkg::FENCE_DEPTH;

	// table and fence list, undefined until written
	logic [IB-1:0] ent_pub_q   [TD];
	logic [IB-1:0] ent_boot_q  [TD];
	logic [IB-1:0] ent_scope_q [TD];
	logic [EB-1:0] ent_epoch_q [TD];
	logic          ent_alive_q [TD];
	logic          ent_fenced_q[TD];
	logic [IB-1:0] fence_q     [FD];

	logic [EB-1:0] epoch_q;
	logic [TC-1:0] used_q;
	logic [FC-1:0] fused_q;
	logic [4:0]    maxpub_q;

	pft_pkg::req_t req_q;
	logic [IB-1:0] id_q, boot_q, scope_q;
	logic [EB-1:0] ep_q;
	logic          alive_in_q, fenced_in_q;

	logic [TC-1:0] fcnt_q;       // find scan index
	logic          found_q;
	logic [TB-1:0] fidx_q;
	logic [FC-1:0] lcnt_q;       // fence list scan index
	logic [IB-1:0] lkey_q;
	logic          listed_q;
	logic [TC-1:0] wcnt_q;       // walk index
	logic          fullerr_q;    // fence list overflow seen
	logic [IB-1:0] fullboot_q;

	logic [3:0]    status_q;
	logic [31:0]   detail_q;
	logic          qalive_q, qfenced_q;

	logic [TB-1:0] widx;
	logic [IB-1:0] fboot;
	assign widx  = wcnt_q[TB-1:0];
	assign fboot = ent_boot_q[fidx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxpub_q <= 5'd16;
		end else if (cfg_we) begin
			maxpub_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= pft_pkg::req_t'(req_type);
			id_q        <= publisher_id;
			boot_q      <= boot_id;
			scope_q     <= scope_id;
			ep_q        <= epoch_value;
			alive_in_q  <= alive_in;
			fenced_in_q <= fenced_in;
		end
	end

	// publisher search, one entry a cycle
	always_ff @(posedge clk) begin
		if (cmd.find_start) begin
			fcnt_q  <= '0;
			found_q <= 1'b0;
		end else if (!sts.find_done) begin
			if (ent_pub_q[fcnt_q[TB-1:0]] == id_q) begin
				found_q <= 1'b1;
				fidx_q  <= fcnt_q[TB-1:0];
			end
			fcnt_q <= fcnt_q + 1'b1;
		end
	end
	assign sts.find_done = found_q || (fcnt_q >= used_q);

	// fence list search, one slot a cycle
	always_ff @(posedge clk) begin
		if (cmd.list_start) begin
			lcnt_q   <= '0;
			listed_q <= 1'b0;
			if (!cmd.list_key_ent) lkey_q <= boot_q;
			else if (pft_pkg::req_t'(req_q) == pft_pkg::REQ_MARK_DEAD) lkey_q <= fboot;
			else lkey_q <= ent_boot_q[widx];
		end else if (!sts.list_done) begin
			if (fence_q[lcnt_q[FB-1:0]] == lkey_q) listed_q <= 1'b1;
			lcnt_q <= lcnt_q + 1'b1;
		end
	end
	assign sts.list_done = listed_q || (lcnt_q >= fused_q);

	assign sts.walk_last = (wcnt_q >= used_q);
	assign sts.need_walk = (req_q == pft_pkg::REQ_FENCE_ALL) ||
		((req_q == pft_pkg::REQ_FENCE_BOOT) && (boot_q != '0));
	assign sts.walk_list = (req_q == pft_pkg::REQ_FENCE_ALL);
	assign sts.req       = req_q;

	logic [TC-1:0] lim;
	assign lim = (maxpub_q < 5'(TD)) ? TC'(maxpub_q) : TC'(TD);

	// main update: decide commits the request, walk_step one entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
			used_q  <= '0;
			fused_q <= '0;
		end else begin
			if (cmd.decide) begin
				unique case (req_q)
					pft_pkg::REQ_REGISTER: begin
						if (id_q != '0 && boot_q != '0 && scope_q != '0 && ep_q != '0 &&
							ep_q == epoch_q && !listed_q) begin
							if (!found_q && used_q < lim) used_q <= used_q + 1'b1;
						end
					end
					pft_pkg::REQ_MARK_DEAD: begin
						if (found_q && !listed_q && fused_q < FC'(FD)) begin
							fused_q <= fused_q + 1'b1;
						end
					end
					pft_pkg::REQ_FENCE_BOOT, pft_pkg::REQ_RESTORE_FENCE: begin
						if ((req_q == pft_pkg::REQ_RESTORE_FENCE || boot_q != '0) &&
							!listed_q && fused_q < FC'(FD)) begin
							fused_q <= fused_q + 1'b1;
						end
					end
					pft_pkg::REQ_ADVANCE: begin
						if (epoch_q != '1) epoch_q <= epoch_q + 1'b1;
					end
					pft_pkg::REQ_RESTORE_EPOCH: begin
						if (ep_q != '0 && ep_q >= epoch_q) epoch_q <= ep_q;
					end
					pft_pkg::REQ_RESTORE_PUB: begin
						if (!found_q && used_q < TC'(TD)) used_q <= used_q + 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.walk_step && sts.walk_list && !listed_q && fused_q < FC'(FD)) begin
				fused_q <= fused_q + 1'b1;
			end
		end
	end

	// fence list write
	always_ff @(posedge clk) begin
		if (cmd.decide && !listed_q && fused_q < FC'(FD)) begin
			if (req_q == pft_pkg::REQ_MARK_DEAD && found_q)
				fence_q[fused_q[FB-1:0]] <= fboot;
			else if ((req_q == pft_pkg::REQ_FENCE_BOOT && boot_q != '0) ||
				req_q == pft_pkg::REQ_RESTORE_FENCE)
				fence_q[fused_q[FB-1:0]] <= boot_q;
		end else if (cmd.walk_step && sts.walk_list && !listed_q && fused_q < FC'(FD)) begin
			fence_q[fused_q[FB-1:0]] <= lkey_q;
		end
	end

	// table writes
	logic          reg_ok;
	logic [TB-1:0] wr_idx;
	assign reg_ok = id_q != '0 && boot_q != '0 && scope_q != '0 && ep_q != '0 &&
		ep_q == epoch_q && !listed_q;
	assign wr_idx = found_q ? fidx_q : used_q[TB-1:0];

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			priority if (req_q == pft_pkg::REQ_REGISTER && reg_ok &&
				(found_q ? (fboot == boot_q) : (used_q < lim))) begin
				ent_pub_q[wr_idx]    <= id_q;
				ent_boot_q[wr_idx]   <= boot_q;
				ent_scope_q[wr_idx]  <= scope_q;
				ent_epoch_q[wr_idx]  <= ep_q;
				ent_alive_q[wr_idx]  <= 1'b1;
				ent_fenced_q[wr_idx] <= 1'b0;
			end else if (req_q == pft_pkg::REQ_RESTORE_PUB &&
				(found_q || used_q < TC'(TD))) begin
				ent_pub_q[wr_idx]    <= id_q;
				ent_boot_q[wr_idx]   <= boot_q;
				ent_scope_q[wr_idx]  <= scope_q;
				ent_epoch_q[wr_idx]  <= ep_q;
				ent_alive_q[wr_idx]  <= alive_in_q;
				ent_fenced_q[wr_idx] <= fenced_in_q;
			end else if (req_q == pft_pkg::REQ_HEARTBEAT && id_q != '0 && boot_q != '0 &&
				ep_q == epoch_q && found_q && fboot == boot_q &&
				!ent_fenced_q[fidx_q] && !listed_q) begin
				ent_alive_q[fidx_q] <= 1'b1;
			end else if (req_q == pft_pkg::REQ_MARK_DEAD && found_q) begin
				ent_alive_q[fidx_q]  <= 1'b0;
				ent_fenced_q[fidx_q] <= 1'b1;
			end else begin
			end
		end else if (cmd.walk_step) begin
			if (sts.walk_list || ent_boot_q[widx] == boot_q) begin
				ent_alive_q[widx]  <= 1'b0;
				ent_fenced_q[widx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			wcnt_q    <= '0;
			fullerr_q <= 1'b0;
		end else if (cmd.walk_step) begin
			wcnt_q <= wcnt_q + 1'b1;
			if (sts.walk_list && !listed_q && fused_q >= FC'(FD) && !fullerr_q) begin
				fullerr_q  <= 1'b1;
				fullboot_q <= lkey_q;
			end
		end
	end

	// result evaluation, taken at decide (walk results folded in at emit)
	logic [3:0]  st_d;
	logic [31:0] dt_d;
	always_comb begin
		st_d = pft_pkg::ST_OK;
		dt_d = '0;
		unique case (req_q)
			pft_pkg::REQ_REGISTER: begin
				priority if (id_q == '0) st_d = pft_pkg::ST_MISS_PUB;
				else if (boot_q == '0) st_d = pft_pkg::ST_MISS_BOOT;
				else if (scope_q == '0) st_d = pft_pkg::ST_MISS_SCOPE;
				else if (ep_q == '0) st_d = pft_pkg::ST_EPOCH_INVALID;
				else if (ep_q != epoch_q) begin
					st_d = pft_pkg::ST_EPOCH_STALE; dt_d = 32'(ep_q);
				end else if (listed_q) begin
					st_d = pft_pkg::ST_BOOT_FENCED; dt_d = 32'(boot_q);
				end else if (found_q && fboot != boot_q) begin
					st_d = pft_pkg::ST_STALE_BOOT; dt_d = 32'(fboot);
				end else if (!found_q && used_q >= lim) begin
					st_d = pft_pkg::ST_LIMIT; dt_d = 32'(lim);
				end else begin
				end
			end
			pft_pkg::REQ_HEARTBEAT: begin
				priority if (id_q == '0) st_d = pft_pkg::ST_MISS_PUB;
				else if (boot_q == '0) st_d = pft_pkg::ST_MISS_BOOT;
				else if (ep_q != epoch_q) begin
					st_d = pft_pkg::ST_EPOCH_STALE; dt_d = 32'(ep_q);
				end else if (!found_q) begin
					st_d = pft_pkg::ST_UNKNOWN; dt_d = 32'(id_q);
				end else if (fboot != boot_q) begin
					st_d = pft_pkg::ST_STALE_BOOT; dt_d = 32'(fboot);
				end else if (ent_fenced_q[fidx_q] || listed_q) begin
					st_d = pft_pkg::ST_FENCED_PUB; dt_d = 32'(boot_q);
				end else begin
				end
			end
			pft_pkg::REQ_MARK_DEAD: begin
				priority if (!found_q) begin
					st_d = pft_pkg::ST_UNKNOWN; dt_d = 32'(id_q);
				end else if (!listed_q && fused_q >= FC'(FD)) begin
					st_d = pft_pkg::ST_FENCE_FULL; dt_d = 32'(fboot);
				end else begin
				end
			end
			pft_pkg::REQ_FENCE_BOOT: begin
				priority if (boot_q == '0) st_d = pft_pkg::ST_MISS_BOOT;
				else if (!listed_q && fused_q >= FC'(FD)) begin
					st_d = pft_pkg::ST_FENCE_FULL; dt_d = 32'(boot_q);
				end else begin
				end
			end
			pft_pkg::REQ_ADVANCE: begin
				if (epoch_q == '1) begin
					st_d = pft_pkg::ST_EPOCH_EXHAUSTED; dt_d = 32'(epoch_q);
				end
			end
			pft_pkg::REQ_RESTORE_EPOCH: begin
				if (ep_q == '0 || ep_q < epoch_q) begin
					st_d = pft_pkg::ST_EPOCH_REJECTED; dt_d = 32'(ep_q);
				end
			end
			pft_pkg::REQ_RESTORE_PUB: begin
				if (!found_q && used_q >= TC'(TD)) begin
					st_d = pft_pkg::ST_LIMIT; dt_d = 32'(TD);
				end
			end
			pft_pkg::REQ_RESTORE_FENCE: begin
				if (!listed_q && fused_q >= FC'(FD)) begin
					st_d = pft_pkg::ST_FENCE_FULL; dt_d = 32'(boot_q);
				end
			end
			pft_pkg::REQ_FENCE_ALL, pft_pkg::REQ_QUERY: ;
			default: st_d = pft_pkg::ST_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			status_q  <= st_d;
			detail_q  <= dt_d;
			qalive_q  <= (req_q == pft_pkg::REQ_QUERY) && found_q &&
				ent_alive_q[fidx_q] && !ent_fenced_q[fidx_q];
			qfenced_q <= (req_q == pft_pkg::REQ_QUERY) && listed_q;
		end else if (cmd.emit && sts.walk_list && fullerr_q) begin
			status_q <= pft_pkg::ST_FENCE_FULL;
			detail_q <= 32'(fullboot_q);
		end
	end

	assign status          = status_q;
	assign detail          = detail_q;
	assign publisher_alive = qalive_q;
	assign boot_is_fenced  = qfenced_q;
	assign epoch_now       = 32'(epoch_q);
	assign entry_count     = 5'(used_q);
endmodule
`default_nettype wire

// ===== src/pft_ctrl.sv =====
// Controller of the publisher fencing table: sequences find, list scan,
// decide and walk steps, and owns the handshakes. Uses pft_pkg.
`default_nettype none
module pft_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire pft_pkg::sts_t sts,
	output pft_pkg::cmd_t      cmd
);
	pft_pkg::state_t state_q, state_d;
	logic            out_valid_q, out_valid_d;
	logic            walk_phase_q, walk_phase_d; // 1: list scan belongs to walk

	assign in_ready  = (state_q == pft_pkg::S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		out_valid_d  = out_valid_q && !out_ready;
		walk_phase_d = walk_phase_q;
		cmd          = '0;
		unique case (state_q)
			pft_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = pft_pkg::S_FIND;
				end
			end
			pft_pkg::S_FIND: begin
				// first cycle restarts the search, the list scan follows
				if (!walk_phase_q) begin
					cmd.find_start = 1'b1;
					walk_phase_d   = 1'b1;
				end else if (sts.find_done) begin
					cmd.list_start   = 1'b1;
					cmd.list_key_ent = (sts.req == pft_pkg::REQ_MARK_DEAD);
					walk_phase_d     = 1'b0;
					state_d          = pft_pkg::S_LIST;
				end
			end
			pft_pkg::S_LIST: begin
				if (sts.list_done) begin
					if (walk_phase_q) begin
						cmd.walk_step = 1'b1;
						state_d       = pft_pkg::S_WALK;
					end else begin
						state_d = pft_pkg::S_DECIDE;
					end
				end
			end
			pft_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.need_walk) begin
					cmd.walk_start = 1'b1;
					state_d        = pft_pkg::S_WALK;
				end else begin
					state_d = pft_pkg::S_DONE;
				end
			end
			pft_pkg::S_WALK: begin
				if (sts.walk_last) begin
					walk_phase_d = 1'b0;
					state_d      = pft_pkg::S_DONE;
				end else if (sts.walk_list) begin
					cmd.list_start   = 1'b1;
					cmd.list_key_ent = 1'b1;
					walk_phase_d     = 1'b1;
					state_d          = pft_pkg::S_LIST;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			pft_pkg::S_DONE: begin
				cmd.emit    = 1'b1;
				out_valid_d = 1'b1;
				state_d     = pft_pkg::S_IDLE;
			end
			default: state_d = pft_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pft_pkg::S_IDLE;
			out_valid_q  <= 1'b0;
			walk_phase_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			out_valid_q  <= out_valid_d;
			walk_phase_q <= walk_phase_d;
		end
	end
endmodule
`default_nettype wire

// ===== src/publisher_fencing_table_core.sv =====
// Top level of the publisher fencing table: controller plus datapath.
// Depends on pft_pkg, pft_ctrl and pft_datapath.
//
// Usage: one request transaction enters on in_valid/in_ready with its fields
// on separate ports; one result transaction leaves on out_valid/out_ready.
// The user writes the publisher limit through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. Each request first
// scans the publisher table (one entry per cycle, stops on a hit), then the fence
// list (one slot per cycle, stops on a hit), then commits. Fence boot with a
// nonzero boot walks all entries once more; fence all walks entries and scans
// the fence list for each. The sequential scans of the table and list set the
// latency, which is largest for fence all on full lists. One request is in
// flight at a time. The result stays in an output register until taken; a new
// request is accepted once it has been taken. Reset clears the epoch, the entry
// and fence counts and sets the publisher limit to 16; table contents are
// undefined until written and never read beyond the counts.
`default_nettype none
module publisher_fencing_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  req_type,
	input  wire logic [15:0] publisher_id,
	input  wire logic [15:0] boot_id,
	input  wire logic [15:0] scope_id,
	input  wire logic [31:0] epoch_value,
	input  wire logic        alive_in,
	input  wire logic        fenced_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [31:0]      detail,
	output logic             publisher_alive,
	output logic             boot_is_fenced,
	output logic [31:0]      epoch_now,
	output logic [4:0]       entry_count
);
	pft_pkg::cmd_t cmd;
	pft_pkg::sts_t sts;

	pft_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	pft_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_wdata,
		.req_type, .publisher_id, .boot_id, .scope_id, .epoch_value,
		.alive_in, .fenced_in, .status, .detail, .publisher_alive,
		.boot_is_fenced, .epoch_now, .entry_count
	);
endmodule
`default_nettype wire

// ===== src/pft_checker.sv =====
// Port-level checker for publisher_fencing_table_core, bound to the top.
// Depends on the top level's ports and the status codes of pft_pkg.
`default_nettype none
module pft_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  status,
	input wire logic [4:0]  entry_count,
	input wire logic        publisher_alive
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while a result waits");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= 5'd16)
		else $error("entry count beyond table depth");
	a_alive_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && publisher_alive |-> status == pft_pkg::ST_OK)
		else $error("alive flag with error status");
endmodule

bind publisher_fencing_table_core pft_checker u_pft_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.status, .entry_count, .publisher_alive
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for publisher_fencing_table_core: drives request transactions and
// checks every result against a behavioral predictor of the fencing table.
// Depends on pft_pkg and the core RTL.
`default_nettype none
module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  req_type = '0;
	logic [15:0] publisher_id = '0;
	logic [15:0] boot_id = '0;
	logic [15:0] scope_id = '0;
	logic [31:0] epoch_value = '0;
	logic        alive_in = 1'b0;
	logic        fenced_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  status;
	logic [31:0] detail;
	logic        publisher_alive;
	logic        boot_is_fenced;
	logic [31:0] epoch_now;
	logic [4:0]  entry_count;

	typedef struct packed {
		logic [3:0]  st;
		logic [31:0] det;
		logic        q_alive;
		logic        q_fenced;
		logic [31:0] ep;
		logic [4:0]  cnt;
	} answer_t;

	answer_t pending_answers[$];

	// predictor state
	logic [31:0] cur_epoch;
	logic [15:0] tab_pub[pft_pkg::TABLE_DEPTH];
	logic [15:0] tab_boot[pft_pkg::TABLE_DEPTH];
	logic [15:0] tab_scope[pft_pkg::TABLE_DEPTH];
	logic [31:0] tab_epoch[pft_pkg::TABLE_DEPTH];
	logic        tab_alive[pft_pkg::TABLE_DEPTH];
	logic        tab_fenced[pft_pkg::TABLE_DEPTH];
	int          n_entries;
	logic [15:0] fence_boots[pft_pkg::FENCE_DEPTH];
	int          n_fenced;
	logic [4:0]  pub_limit;

	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	bit idle_on = 1'b1;

	publisher_fencing_table_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.publisher_id(publisher_id), .boot_id(boot_id), .scope_id(scope_id),
		.epoch_value(epoch_value), .alive_in(alive_in), .fenced_in(fenced_in),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.detail(detail), .publisher_alive(publisher_alive),
		.boot_is_fenced(boot_is_fenced), .epoch_now(epoch_now),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int find_pub(logic [15:0] id);
		for (int i = 0; i < n_entries; i++)
			if (tab_pub[i] == id)
				return i;
		return -1;
	endfunction

	function automatic bit boot_in_fence(logic [15:0] b);
		for (int i = 0; i < n_fenced; i++)
			if (fence_boots[i] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit add_fence(logic [15:0] b);
		if (boot_in_fence(b))
			return 1'b1;
		if (n_fenced >= pft_pkg::FENCE_DEPTH)
			return 1'b0;
		fence_boots[n_fenced] = b;
		n_fenced++;
		return 1'b1;
	endfunction

	function automatic answer_t predict_table(logic [3:0] rq, logic [15:0] id,
			logic [15:0] b, logic [15:0] sc, logic [31:0] ev, logic al, logic fe);
		answer_t a;
		int k;
		int lim;
		a = '0;
		a.st = pft_pkg::ST_OK;
		case (rq)
		pft_pkg::REQ_REGISTER: begin
			lim = (int'(pub_limit) < pft_pkg::TABLE_DEPTH) ? int'(pub_limit)
				: pft_pkg::TABLE_DEPTH;
			k = find_pub(id);
			if (id == 0) a.st = pft_pkg::ST_MISS_PUB;
			else if (b == 0) a.st = pft_pkg::ST_MISS_BOOT;
			else if (sc == 0) a.st = pft_pkg::ST_MISS_SCOPE;
			else if (ev == 0) a.st = pft_pkg::ST_EPOCH_INVALID;
			else if (ev != cur_epoch) begin
				a.st = pft_pkg::ST_EPOCH_STALE; a.det = ev;
			end else if (boot_in_fence(b)) begin
				a.st = pft_pkg::ST_BOOT_FENCED; a.det = 32'(b);
			end else if (k >= 0) begin
				if (tab_boot[k] != b) begin
					a.st = pft_pkg::ST_STALE_BOOT;
					a.det = 32'(tab_boot[k]);
				end else begin
					tab_scope[k] = sc; tab_epoch[k] = ev;
					tab_alive[k] = 1'b1; tab_fenced[k] = 1'b0;
				end
			end else if (n_entries >= lim) begin
				a.st = pft_pkg::ST_LIMIT; a.det = lim;
			end else begin
				tab_pub[n_entries] = id; tab_boot[n_entries] = b;
				tab_scope[n_entries] = sc; tab_epoch[n_entries] = ev;
				tab_alive[n_entries] = 1'b1; tab_fenced[n_entries] = 1'b0;
				n_entries++;
			end
		end
		pft_pkg::REQ_HEARTBEAT: begin
			k = find_pub(id);
			if (id == 0) a.st = pft_pkg::ST_MISS_PUB;
			else if (b == 0) a.st = pft_pkg::ST_MISS_BOOT;
			else if (ev != cur_epoch) begin
				a.st = pft_pkg::ST_EPOCH_STALE; a.det = ev;
			end else if (k < 0) begin
				a.st = pft_pkg::ST_UNKNOWN; a.det = 32'(id);
			end else if (tab_boot[k] != b) begin
				a.st = pft_pkg::ST_STALE_BOOT; a.det = 32'(tab_boot[k]);
			end else if (tab_fenced[k] || boot_in_fence(b)) begin
				a.st = pft_pkg::ST_FENCED_PUB; a.det = 32'(b);
			end else
				tab_alive[k] = 1'b1;
		end
		pft_pkg::REQ_MARK_DEAD: begin
			k = find_pub(id);
			if (k < 0) begin
				a.st = pft_pkg::ST_UNKNOWN; a.det = 32'(id);
			end else begin
				tab_alive[k] = 1'b0;
				tab_fenced[k] = 1'b1;
				if (!add_fence(tab_boot[k])) begin
					a.st = pft_pkg::ST_FENCE_FULL; a.det = 32'(tab_boot[k]);
				end
			end
		end
		pft_pkg::REQ_FENCE_BOOT: begin
			if (b == 0)
				a.st = pft_pkg::ST_MISS_BOOT;
			else begin
				if (!add_fence(b)) begin
					a.st = pft_pkg::ST_FENCE_FULL; a.det = 32'(b);
				end
				for (int i = 0; i < n_entries; i++)
					if (tab_boot[i] == b) begin
						tab_fenced[i] = 1'b1;
						tab_alive[i] = 1'b0;
					end
			end
		end
		pft_pkg::REQ_ADVANCE: begin
			if (cur_epoch == '1) begin
				a.st = pft_pkg::ST_EPOCH_EXHAUSTED; a.det = cur_epoch;
			end else cur_epoch++;
		end
		pft_pkg::REQ_RESTORE_EPOCH: begin
			if (ev == 0 || ev < cur_epoch) begin
				a.st = pft_pkg::ST_EPOCH_REJECTED; a.det = ev;
			end else cur_epoch = ev;
		end
		pft_pkg::REQ_RESTORE_PUB: begin
			k = find_pub(id);
			if (k < 0 && n_entries >= pft_pkg::TABLE_DEPTH) begin
				a.st = pft_pkg::ST_LIMIT; a.det = pft_pkg::TABLE_DEPTH;
			end else begin
				if (k < 0) begin
					k = n_entries;
					n_entries++;
				end
				tab_pub[k] = id; tab_boot[k] = b; tab_scope[k] = sc;
				tab_epoch[k] = ev; tab_alive[k] = al; tab_fenced[k] = fe;
			end
		end
		pft_pkg::REQ_RESTORE_FENCE: begin
			if (!add_fence(b)) begin
				a.st = pft_pkg::ST_FENCE_FULL; a.det = 32'(b);
			end
		end
		pft_pkg::REQ_FENCE_ALL: begin
			for (int i = 0; i < n_entries; i++) begin
				tab_alive[i] = 1'b0;
				tab_fenced[i] = 1'b1;
				if (!add_fence(tab_boot[i]) && a.st == pft_pkg::ST_OK) begin
					a.st = pft_pkg::ST_FENCE_FULL; a.det = 32'(tab_boot[i]);
				end
			end
		end
		pft_pkg::REQ_QUERY: begin
			k = find_pub(id);
			a.q_alive = (k >= 0) && tab_alive[k] && !tab_fenced[k];
			a.q_fenced = boot_in_fence(b);
		end
		default: a.st = pft_pkg::ST_UNKNOWN;
		endcase
		a.ep = cur_epoch;
		a.cnt = n_entries[4:0];
		return a;
	endfunction

	// drop valid only when a gap is taken, so valid moves once per step
	task automatic idle_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [3:0] rq, logic [15:0] id, logic [15:0] b,
			logic [15:0] sc, logic [31:0] ev, logic al = 1'b0, logic fe = 1'b0);
		idle_gap();
		pending_answers.insert(pending_answers.size(),
			predict_table(rq, id, b, sc, ev, al, fe));
		in_valid <= 1'b1;
		req_type <= rq; publisher_id <= id; boot_id <= b; scope_id <= sc;
		epoch_value <= ev; alive_in <= al; fenced_in <= fe;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic set_limit(logic [4:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pub_limit = v;
	endtask

	// receiver side: random stalls, then compare each result transaction
	initial begin
		int stall;
		answer_t exp_a, got;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{status, detail, publisher_alive, boot_is_fenced,
					epoch_now, entry_count};
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result status=%0d", got.st);
				end else begin
					exp_a = pending_answers.pop_front();
					n_checked++;
					if (got !== exp_a) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp st=%0d det=%0h qa=%0b qf=%0b ep=%0h cnt=%0d",
								exp_a.st, exp_a.det, exp_a.q_alive, exp_a.q_fenced,
								exp_a.ep, exp_a.cnt);
							$display("          got st=%0d det=%0h qa=%0b qf=%0b ep=%0h cnt=%0d",
								got.st, got.det, got.q_alive, got.q_fenced,
								got.ep, got.cnt);
						end
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic test_field_checks();
		send_request(pft_pkg::REQ_QUERY, 16'h0, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_REGISTER, 16'h0, 16'h1, 16'h1, 32'h1);
		send_request(pft_pkg::REQ_REGISTER, 16'h1, 16'h0, 16'h1, 32'h1);
		send_request(pft_pkg::REQ_REGISTER, 16'h1, 16'h1, 16'h0, 32'h1);
		send_request(pft_pkg::REQ_REGISTER, 16'h1, 16'h1, 16'h1, 32'h0);
		send_request(pft_pkg::REQ_REGISTER, 16'h1, 16'h1, 16'h1, 32'h5);
		send_request(pft_pkg::REQ_ADVANCE, 16'h0, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_REGISTER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h1);
		send_request(pft_pkg::REQ_REGISTER, 16'hFFFF, 16'h1234, 16'h1, 32'h1);
		send_request(pft_pkg::REQ_HEARTBEAT, 16'hFFFF, 16'hFFFF, 16'h0, 32'h1);
		send_request(pft_pkg::REQ_HEARTBEAT, 16'h7, 16'h7, 16'h0, 32'h1);
		send_request(pft_pkg::REQ_HEARTBEAT, 16'h0, 16'h7, 16'h0, 32'h1);
		send_request(pft_pkg::REQ_HEARTBEAT, 16'h7, 16'h0, 16'h0, 32'h1);
		send_request(pft_pkg::REQ_HEARTBEAT, 16'hFFFF, 16'hFFFF, 16'h0, 32'h3);
		send_request(pft_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_MARK_DEAD, 16'hFFFF, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_MARK_DEAD, 16'h55, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_REGISTER, 16'hAA, 16'hFFFF, 16'h2, 32'h1);
		send_request(pft_pkg::REQ_HEARTBEAT, 16'hFFFF, 16'hFFFF, 16'h0, 32'h1);
		send_request(pft_pkg::REQ_FENCE_BOOT, 16'h0, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_RESTORE_PUB, 16'h0, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1);
		send_request(4'd10, 16'h1, 16'h1, 16'h1, 32'h1);
		send_request(4'd15, 16'h1, 16'h1, 16'h1, 32'h1);
	endtask

	task automatic test_epoch_edges();
		send_request(pft_pkg::REQ_RESTORE_EPOCH, 16'h0, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_RESTORE_EPOCH, 16'h0, 16'h0, 16'h0, 32'hFFFFFFFE);
		send_request(pft_pkg::REQ_ADVANCE, 16'h0, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_ADVANCE, 16'h0, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_RESTORE_EPOCH, 16'h0, 16'h0, 16'h0, 32'h3);
		send_request(pft_pkg::REQ_RESTORE_EPOCH, 16'h0, 16'h0, 16'h0, 32'hFFFFFFFF);
	endtask

	// fill the table and the fence list to their depths
	task automatic test_full_tables();
		send_request(pft_pkg::REQ_RESTORE_EPOCH, 16'h0, 16'h0, 16'h0, 32'hFFFFFFFF);
		for (int i = 0; i < 18; i++)
			send_request(pft_pkg::REQ_RESTORE_PUB, 16'(16'h100 + i), 16'(16'h200 + i),
				16'h1, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		send_request(pft_pkg::REQ_FENCE_ALL, 16'h0, 16'h0, 16'h0, 32'h0);
		for (int i = 0; i < 18; i++)
			send_request(pft_pkg::REQ_RESTORE_FENCE, 16'h0, 16'(16'h300 + i), 16'h0,
				32'h0);
		send_request(pft_pkg::REQ_FENCE_BOOT, 16'h0, 16'h999, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_MARK_DEAD, 16'h101, 16'h0, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_QUERY, 16'h101, 16'h301, 16'h0, 32'h0);
		send_request(pft_pkg::REQ_FENCE_ALL, 16'h0, 16'h0, 16'h0, 32'h0);
	endtask

	// ids from a small pool unless loose, so that requests hit existing entries
	task automatic random_request(bit loose);
		logic [3:0] rq;
		logic [15:0] id, b;
		logic [31:0] ev;
		rq = (loose && $urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
			: 4'($urandom_range(0, 9));
		id = loose ? 16'($urandom) : 16'($urandom_range(0, 12));
		b = loose ? 16'($urandom) : 16'(id + $urandom_range(0, 1));
		if (rq == pft_pkg::REQ_ADVANCE || rq == pft_pkg::REQ_RESTORE_EPOCH)
			ev = (cur_epoch > 32'hFFFFFF00 || $urandom_range(0, 7) == 0) ? $urandom
				: cur_epoch + $urandom_range(0, 2);
		else
			ev = $urandom_range(0, 5) == 0 ? $urandom : cur_epoch;
		send_request(rq, id, b, loose ? 16'($urandom) : 16'($urandom_range(0, 3)),
			ev, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_traffic(int n, bit loose);
		for (int i = 0; i < n; i++)
			random_request(loose);
	endtask

	initial begin
		cur_epoch = '0;
		n_entries = 0;
		n_fenced = 0;
		pub_limit = 5'd16;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_checks();
		test_epoch_edges();
		set_limit(5'd0);
		send_request(pft_pkg::REQ_REGISTER, 16'h9, 16'h9, 16'h9, cur_epoch);
		test_full_tables();
		// fresh contents are not reachable without reset, so vary limits on top
		set_limit(5'd31);
		test_random_traffic(150, 1'b0);
		set_limit(5'd3);
		test_random_traffic(150, 1'b1);
		set_limit(5'd16);
		test_random_traffic(150, 1'b0);
		idle_on = 1'b0;
		test_random_traffic(150, 1'b1);
		drain();
		$display("Covered %0d requests and %0d checked results over limits 0, 3, 16, 31,",
			n_sent, n_checked);
		$display("including full table, full fence list and epoch wrap limits.");
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#30000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
src/pft_pkg.sv
src/pft_datapath.sv
src/pft_ctrl.sv
src/publisher_fencing_table_core.sv
src/pft_checker.sv
test/tb.sv
